// ===== sv/vertex_transform_project_assert.svh =====
// Assertion macros used by the vertex transform divider RTL.
// No dependencies; empty bodies when SYNTHESIS is defined.
`ifndef VERTEX_TRANSFORM_PROJECT_ASSERT_SVH
`define VERTEX_TRANSFORM_PROJECT_ASSERT_SVH
`ifndef SYNTHESIS
`define VTP_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define VTP_ASSERT_RST(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define VTP_ASSERT(lbl, ck, rn, prop, msg)
`define VTP_ASSERT_RST(lbl, ck, prop, msg)
`endif
`endif

// ===== sv/vtp_pkg.sv =====
// Shared constants and types for the vertex transform block.
// No dependencies.
`timescale 1ns / 1ps
package vtp_pkg;
  localparam int CW_DEF   = 32;
  localparam int FB_DEF   = 16;
  localparam int FIELD_W  = 32;
  localparam int NUM_REGS = 8;
  localparam int REG_W    = 64;
  localparam int ADDR_W   = 6;
  localparam int IDX_W    = 3;

  typedef logic [REG_W-1:0] vtp_reg_t;

  localparam vtp_reg_t REG_RESET [NUM_REGS] = '{
    64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
    64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000
  };

  // sideband that travels with each item
  typedef struct packed {
    logic dv;   // divide asked for
    logic wz;   // divide asked but w was zero
    logic sat;  // some value clamped so far
  } vtp_flags_t;
endpackage

// ===== sv/vtp_if.sv =====
// Stream channel interfaces for vertex items and result items.
// Depends on vtp_pkg.
`timescale 1ns / 1ps
interface vtp_in_if;
  import vtp_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] vec_x;
  logic [FIELD_W-1:0] vec_y;
  logic [FIELD_W-1:0] vec_z;
  logic [FIELD_W-1:0] vec_w;
  logic               apply_divide;
  modport source (output valid, vec_x, vec_y, vec_z, vec_w, apply_divide, input ready);
  modport sink (input valid, vec_x, vec_y, vec_z, vec_w, apply_divide, output ready);
endinterface

interface vtp_out_if;
  import vtp_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] out_x;
  logic [FIELD_W-1:0] out_y;
  logic [FIELD_W-1:0] out_z;
  logic [FIELD_W-1:0] out_w;
  logic               w_was_zero;
  logic               saturated;
  modport source (output valid, out_x, out_y, out_z, out_w, w_was_zero, saturated,
                  input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, w_was_zero, saturated,
                output ready);
endinterface

// ===== sv/vtp_mac.sv =====
// Matrix-vector multiply: capture, products, row sums, shift and saturate.
// Depends on vtp_pkg.
`timescale 1ns / 1ps
module vtp_mac #(
  parameter int CW = vtp_pkg::CW_DEF,
  parameter int FB = vtp_pkg::FB_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic [3:0][CW-1:0]           v_in,
  input  logic                         div_in,
  input  logic [3:0][3:0][CW-1:0]      coef_in,
  output logic                         vld_out,
  output logic [3:0][CW-1:0]           t_out,
  output vtp_pkg::vtp_flags_t          fl_out
);
  import vtp_pkg::*;

  localparam int PW = 2 * CW;
  localparam int SW = PW + 2;
  localparam int HW = SW - FB;

  logic                    vld1_r, vld2_r, vld3_r, vld4_r;
  logic                    div1_r, div2_r, div3_r;
  logic [3:0][CW-1:0]      v1_r;
  logic [3:0][3:0][CW-1:0] c1_r;
  logic [3:0][3:0][PW-1:0] p2_nxt, p2_r;
  logic [3:0][SW-1:0]      s3_nxt, s3_r;
  logic [3:0][CW-1:0]      t4_nxt, t4_r;
  vtp_flags_t              fl4_nxt, fl4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1_r   <= v_in;
      c1_r   <= coef_in;
      div1_r <= div_in;
      p2_r   <= p2_nxt;
      div2_r <= div1_r;
      s3_r   <= s3_nxt;
      div3_r <= div2_r;
      t4_r   <= t4_nxt;
      fl4_r  <= fl4_nxt;
    end
  end

  always_comb begin
    logic signed [CW-1:0] ca, va;
    logic signed [PW-1:0] pp;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        ca = c1_r[r][c];
        va = v1_r[c];
        pp = ca * va;
        p2_nxt[r][c] = pp;
      end
    end
  end

  always_comb begin
    logic [SW-1:0] acc;
    for (int r = 0; r < 4; r++) begin
      acc = '0;
      for (int c = 0; c < 4; c++) begin
        acc = acc + {{2{p2_r[r][c][PW-1]}}, p2_r[r][c]};
      end
      s3_nxt[r] = acc;
    end
  end

  // floor shift is just dropping the fraction bits; clamp when the top bits disagree
  always_comb begin
    logic [HW-1:0] sh;
    logic          ovf;
    fl4_nxt.sat = 1'b0;
    for (int r = 0; r < 4; r++) begin
      sh  = s3_r[r][SW-1:FB];
      ovf = (sh[HW-1:CW-1] != '0) && (sh[HW-1:CW-1] != '1);
      if (ovf) begin
        t4_nxt[r]   = sh[HW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        fl4_nxt.sat = 1'b1;
      end else begin
        t4_nxt[r] = sh[CW-1:0];
      end
    end
    fl4_nxt.dv = div3_r;
    fl4_nxt.wz = div3_r && (t4_nxt[3] == '0);
  end

  assign vld_out = vld4_r;
  assign t_out   = t4_r;
  assign fl_out  = fl4_r;
endmodule

// ===== sv/vtp_div.sv =====
// Perspective divide: pipelined restoring divider, one quotient bit per stage,
// three lanes sharing the w divisor. Depends on vtp_pkg and the assert header.
`timescale 1ns / 1ps
`include "vertex_transform_project_assert.svh"
module vtp_div #(
  parameter int CW = vtp_pkg::CW_DEF,
  parameter int FB = vtp_pkg::FB_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_in,
  input  logic [3:0][CW-1:0]   t_in,
  input  vtp_pkg::vtp_flags_t  fl_in,
  output logic                 vld_out,
  output logic [3:0][CW-1:0]   t_out,
  output vtp_pkg::vtp_flags_t  fl_out
);
  import vtp_pkg::*;

  localparam int NB = CW + FB;

  logic [NB:0]                 vld_r;
  logic                        act_r  [NB+1];
  logic [2:0][CW-1:0]          rem_r  [NB+1];
  logic [2:0][NB-1:0]          num_r  [NB+1];
  logic [2:0][NB-1:0]          q_r    [NB+1];
  logic [2:0]                  neg_r  [NB+1];
  logic [CW-1:0]               dmag_r [NB+1];
  logic [3:0][CW-1:0]          t_r    [NB+1];
  vtp_flags_t                  fl_r   [NB+1];

  logic                        vldf_r;
  logic [3:0][CW-1:0]          tf_r, tf_nxt;
  vtp_flags_t                  flf_r, flf_nxt;

  // setup: magnitudes and quotient signs
  always_ff @(posedge clk) begin
    logic [CW-1:0] nmag;
    if (en) begin
      act_r[0]  <= fl_in.dv && !fl_in.wz;
      dmag_r[0] <= t_in[3][CW-1] ? (~t_in[3] + 1'b1) : t_in[3];
      t_r[0]    <= t_in;
      fl_r[0]   <= fl_in;
      for (int i = 0; i < 3; i++) begin
        nmag         = t_in[i][CW-1] ? (~t_in[i] + 1'b1) : t_in[i];
        num_r[0][i] <= {nmag, {FB{1'b0}}};
        rem_r[0][i] <= '0;
        q_r[0][i]   <= '0;
        neg_r[0][i] <= t_in[i][CW-1] ^ t_in[3][CW-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      vldf_r <= 1'b0;
    end else if (en) begin
      vld_r  <= {vld_r[NB-1:0], vld_in};
      vldf_r <= vld_r[NB];
    end
  end

  for (genvar k = 0; k < NB; k++) begin : g_step
    logic [2:0][CW-1:0] rem_nxt;
    logic [2:0]         qb;

    always_comb begin
      logic [CW:0] trial, diff;
      for (int i = 0; i < 3; i++) begin
        trial = {rem_r[k][i], num_r[k][i][NB-1]};
        diff  = trial - {1'b0, dmag_r[k]};
        qb[i] = trial >= {1'b0, dmag_r[k]};
        rem_nxt[i] = qb[i] ? diff[CW-1:0] : trial[CW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        act_r[k+1]  <= act_r[k];
        dmag_r[k+1] <= dmag_r[k];
        t_r[k+1]    <= t_r[k];
        fl_r[k+1]   <= fl_r[k];
        neg_r[k+1]  <= neg_r[k];
        for (int i = 0; i < 3; i++) begin
          rem_r[k+1][i] <= rem_nxt[i];
          num_r[k+1][i] <= {num_r[k][i][NB-2:0], 1'b0};
          q_r[k+1][i]   <= {q_r[k][i][NB-2:0], qb[i]};
        end
      end
    end
  end

  // sign the quotient and clamp
  always_comb begin
    logic [NB-1:0] q;
    logic          ls;
    logic          any_sat;
    any_sat = 1'b0;
    tf_nxt  = t_r[NB];
    for (int i = 0; i < 3; i++) begin
      q = q_r[NB][i];
      if (neg_r[NB][i]) begin
        ls = (q[NB-1:CW] != '0) || (q[CW-1] && (q[CW-2:0] != '0));
        if (act_r[NB]) begin
          tf_nxt[i] = ls ? {1'b1, {(CW-1){1'b0}}} : (~q[CW-1:0] + 1'b1);
        end
      end else begin
        ls = (q[NB-1:CW-1] != '0);
        if (act_r[NB]) begin
          tf_nxt[i] = ls ? {1'b0, {(CW-1){1'b1}}} : {1'b0, q[CW-2:0]};
        end
      end
      any_sat = any_sat | ls;
    end
    flf_nxt     = fl_r[NB];
    flf_nxt.sat = fl_r[NB].sat | (act_r[NB] & any_sat);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tf_r  <= tf_nxt;
      flf_r <= flf_nxt;
    end
  end

  assign vld_out = vldf_r;
  assign t_out   = tf_r;
  assign fl_out  = flf_r;

  `VTP_ASSERT(a_rem_lt_div, clk, rst_n,
    vld_r[NB] && act_r[NB] |-> (rem_r[NB][0] < dmag_r[NB]) &&
    (rem_r[NB][1] < dmag_r[NB]) && (rem_r[NB][2] < dmag_r[NB]),
    "remainder not below divisor")
  `VTP_ASSERT(a_stall_hold, clk, rst_n, !en && vldf_r |=> vldf_r, "result lost during stall")
  `VTP_ASSERT_RST(a_rst_clear, clk, $past(!rst_n) |-> !vldf_r && (vld_r == '0),
    "valid bits not cleared by reset")
endmodule

// ===== sv/vertex_transform_project.sv =====
// Vertex transform: one Q16.16 vertex (x, y, z, w) per clock is multiplied by a
// 4x4 matrix held in eight 64-bit APB registers, row sums floored and saturated,
// then x, y and z optionally divided by the transformed w. The pipeline takes a
// new item every cycle unless the result side stalls; the divider resolves one
// quotient bit per stage. When the result side stalls, the whole pipeline holds.
// Registers sit at byte address 8*i; the user must write them only while no item
// is in flight, as the block itself does not enforce this.
// Depends on vtp_pkg, vtp_if, vtp_mac and vtp_div.
`timescale 1ns / 1ps
module vertex_transform_project #(
  parameter int COORD_WIDTH   = vtp_pkg::CW_DEF,
  parameter int FRACTION_BITS = vtp_pkg::FB_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  vtp_in_if.sink                      in_chan,
  vtp_out_if.source                   out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vtp_pkg::ADDR_W-1:0]  paddr,
  input  logic [vtp_pkg::REG_W-1:0]   pwdata,
  output logic [vtp_pkg::REG_W-1:0]   prdata,
  output logic                        pready
);
  import vtp_pkg::*;

  localparam int CW = COORD_WIDTH;

  vtp_reg_t                regs_r [NUM_REGS];
  logic [IDX_W-1:0]        idx;
  logic                    en;
  logic [3:0][CW-1:0]      v_in;
  logic [3:0][3:0][CW-1:0] coef;
  logic                    mac_vld;
  logic [3:0][CW-1:0]      mac_t;
  vtp_flags_t              mac_fl;
  logic                    div_vld;
  logic [3:0][CW-1:0]      div_t;
  vtp_flags_t              div_fl;

  assign idx    = paddr[ADDR_W-1:ADDR_W-IDX_W];
  assign pready = 1'b1;
  assign prdata = regs_r[idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) regs_r[i] <= REG_RESET[i];
    end else if (psel && penable && pwrite) begin
      regs_r[idx] <= pwdata;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (c % 2 == 1) coef[r][c] = regs_r[r*2 + c/2][CW-1:0];
        else            coef[r][c] = regs_r[r*2 + c/2][32+CW-1:32];
      end
    end
  end

  assign en            = !out_chan.valid || out_chan.ready;
  assign in_chan.ready = en;
  assign v_in = {in_chan.vec_w[CW-1:0], in_chan.vec_z[CW-1:0],
                 in_chan.vec_y[CW-1:0], in_chan.vec_x[CW-1:0]};

  vtp_mac #(.CW(CW), .FB(FRACTION_BITS)) u_mac (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(in_chan.valid), .v_in(v_in), .div_in(in_chan.apply_divide),
    .coef_in(coef),
    .vld_out(mac_vld), .t_out(mac_t), .fl_out(mac_fl)
  );

  vtp_div #(.CW(CW), .FB(FRACTION_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_in(mac_vld), .t_in(mac_t), .fl_in(mac_fl),
    .vld_out(div_vld), .t_out(div_t), .fl_out(div_fl)
  );

  assign out_chan.valid      = div_vld;
  assign out_chan.out_x      = FIELD_W'($signed(div_t[0]));
  assign out_chan.out_y      = FIELD_W'($signed(div_t[1]));
  assign out_chan.out_z      = FIELD_W'($signed(div_t[2]));
  assign out_chan.out_w      = FIELD_W'($signed(div_t[3]));
  assign out_chan.w_was_zero = div_fl.wz;
  assign out_chan.saturated  = div_fl.sat;
endmodule

// ===== verif/vtp_checker.sv =====
// Result checker for the vertex transform: snoops APB writes and both channels,
// predicts each result item and compares it field by field.
// Depends on vtp_pkg and vtp_if.
`timescale 1ns / 1ps
module vtp_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  vtp_in_if                          in_m,
  vtp_out_if                         out_m,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [vtp_pkg::ADDR_W-1:0] paddr,
  input  logic [vtp_pkg::REG_W-1:0]  pwdata,
  output int                         fail_count,
  output int                         pending,
  output int                         result_count
);
  import vtp_pkg::*;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
    logic        wz;
    logic        sat;
  } vertex_out_t;

  localparam logic signed [67:0] ROW_MAX = 68'sh7FFFFFFF;
  localparam logic signed [67:0] ROW_MIN = -ROW_MAX - 1;

  vtp_reg_t    matrix_regs [NUM_REGS];
  vertex_out_t vertex_q [$];

  function automatic logic signed [31:0] coef_of(int r, int c);
    vtp_reg_t rg;
    rg = matrix_regs[r * 2 + c / 2];
    return (c % 2) ? rg[31:0] : rg[63:32];
  endfunction

  function automatic logic signed [67:0] clamp32(logic signed [67:0] v, ref logic sat);
    if (v > ROW_MAX) begin
      sat = 1'b1;
      return ROW_MAX;
    end
    if (v < ROW_MIN) begin
      sat = 1'b1;
      return ROW_MIN;
    end
    return v;
  endfunction

  function automatic vertex_out_t transform_vertex(logic [31:0] vx, logic [31:0] vy,
                                                   logic [31:0] vz, logic [31:0] vw,
                                                   logic dv);
    logic signed [31:0] v [4];
    logic signed [67:0] t [4];
    logic signed [67:0] acc;
    logic signed [67:0] num;
    logic signed [67:0] q;
    logic               sat;
    vertex_out_t        res;
    v[0] = vx; v[1] = vy; v[2] = vz; v[3] = vw;
    sat = 1'b0;
    res.wz = 1'b0;
    for (int r = 0; r < 4; r++) begin
      acc = '0;
      for (int c = 0; c < 4; c++) acc += coef_of(r, c) * v[c];
      t[r] = clamp32(acc >>> FB_DEF, sat);  // floor shift
    end
    if (dv) begin
      if (t[3] == 0) res.wz = 1'b1;
      else begin
        for (int i = 0; i < 3; i++) begin
          num = t[i] <<< FB_DEF;
          q = num / t[3];  // truncates toward zero
          t[i] = clamp32(q, sat);
        end
      end
    end
    res.x = t[0][31:0];
    res.y = t[1][31:0];
    res.z = t[2][31:0];
    res.w = t[3][31:0];
    res.sat = sat;
    return res;
  endfunction

  always @(posedge clk) begin
    vertex_out_t e;
    if (!rst_n) begin
      matrix_regs = REG_RESET;
      vertex_q.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready && (paddr >> 3) < NUM_REGS)
        matrix_regs[paddr >> 3] = pwdata;
      if (in_m.valid && in_m.ready)
        vertex_q.push_back(transform_vertex(in_m.vec_x, in_m.vec_y, in_m.vec_z,
                                            in_m.vec_w, in_m.apply_divide));
      if (out_m.valid && out_m.ready) begin
        result_count <= result_count + 1;
        if (vertex_q.size() == 0) begin
          $error("result item with no item pending");
          fail_count <= fail_count + 1;
        end else begin
          e = vertex_q.pop_front();
          if (out_m.out_x !== e.x || out_m.out_y !== e.y || out_m.out_z !== e.z ||
              out_m.out_w !== e.w || out_m.w_was_zero !== e.wz ||
              out_m.saturated !== e.sat)
            fail_count <= fail_count + 1;
          if (out_m.out_x !== e.x) $error("out_x exp %h got %h", e.x, out_m.out_x);
          if (out_m.out_y !== e.y) $error("out_y exp %h got %h", e.y, out_m.out_y);
          if (out_m.out_z !== e.z) $error("out_z exp %h got %h", e.z, out_m.out_z);
          if (out_m.out_w !== e.w) $error("out_w exp %h got %h", e.w, out_m.out_w);
          if (out_m.w_was_zero !== e.wz)
            $error("w_was_zero exp %b got %b", e.wz, out_m.w_was_zero);
          if (out_m.saturated !== e.sat)
            $error("saturated exp %b got %b", e.sat, out_m.saturated);
        end
      end
    end
    pending <= vertex_q.size();
  end
endmodule

// ===== verif/testbench.sv =====
// Top of the vertex transform testbench: clock, reset, APB matrix setup,
// vertex stimulus with random idling, and the verdict. Depends on vtp_pkg,
// vtp_if, vtp_checker and the vertex_transform_project RTL.
`timescale 1ns / 1ps
module testbench;
  import vtp_pkg::*;

  localparam int LATENCY = 54;
  localparam int LIMIT   = 300000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [REG_W-1:0]    pwdata = '0;
  logic [REG_W-1:0]    prdata;
  logic                pready;
  int                  fail_count;
  int                  pending;
  int                  result_count;
  int                  cycle_count = 0;
  int                  sent = 0;
  logic                no_idle = 1'b0;

  vtp_in_if  in_if ();
  vtp_out_if out_if ();

  initial begin
    in_if.valid = 1'b0;
    in_if.vec_x = '0;
    in_if.vec_y = '0;
    in_if.vec_z = '0;
    in_if.vec_w = '0;
    in_if.apply_divide = 1'b0;
    out_if.ready = 1'b0;
  end

  always #5 clk = ~clk;

  vertex_transform_project u_top (
    .clk, .rst_n, .in_chan(in_if), .out_chan(out_if),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  vtp_checker u_checker (
    .clk, .rst_n, .in_m(in_if), .out_m(out_if),
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count, .pending, .result_count
  );

  always @(posedge clk)
    out_if.ready <= rst_n && (no_idle || $urandom_range(99) >= 18);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic write_reg(int idx, logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx * 8);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 6) @(posedge clk);
  endtask

  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [31:0] w, logic dv);
    logic ok;
    if (!no_idle && $urandom_range(99) < 18) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 40);
    end
    in_if.valid <= 1'b1;
    in_if.vec_x <= x;
    in_if.vec_y <= y;
    in_if.vec_z <= z;
    in_if.vec_w <= w;
    in_if.apply_divide <= dv;
    do begin
      @(negedge clk);
      ok = in_if.ready;
      @(posedge clk);
    end while (!ok);
    sent++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      3, 4:    return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
      5:       return 32'($signed($urandom_range(512)) - 256);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(7))
      0:       return 32'h0;
      1:       return 32'h0001_0000;
      2, 3:    return 32'($signed($urandom_range(4 << 16)) - (2 << 16));
      default: return $urandom;
    endcase
  endfunction

  task automatic random_vertices(int n);
    logic [31:0] w;
    repeat (n) begin
      // zero w now and then so the divide-skip path stays busy
      w = ($urandom_range(9) == 0) ? 32'h0 : rand_coord();
      send_vertex(rand_coord(), rand_coord(), rand_coord(), w, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    logic [31:0] ext [4];
    ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity matrix out of reset: extremes, zero w, divide on and off
    for (int i = 0; i < 4; i++) begin
      send_vertex(ext[i], ext[i], ext[i], ext[i], 1'b0);
      send_vertex(ext[i], ext[3 - i], ext[i], ext[3 - i], 1'b1);
    end
    send_vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0, 1'b1);
    send_vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0, 1'b0);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
    send_vertex(32'hFFFF_8000, 32'h0000_8000, 32'h0003_0000, 32'h0002_0000, 1'b1);
    send_vertex(32'h0005_0000, 32'hFFFB_0000, 32'h0000_0001, 32'hFFFD_0000, 1'b1);
    random_vertices(230);

    for (int p = 1; p < 8; p++) begin
      in_if.valid <= 1'b0;
      drain();
      no_idle = (p == 3);  // one phase runs flat out on both sides
      for (int r = 0; r < NUM_REGS; r++) begin
        case (p)
          1:       write_reg(r, 64'hFFFF_FFFF_FFFF_FFFF);
          2:       write_reg(r, 64'h7FFF_FFFF_7FFF_FFFF);
          3:       write_reg(r, 64'h8000_0000_8000_0000);
          5:       write_reg(r, (r == 7) ? 64'h0 : {rand_coef(), rand_coef()});
          6:       write_reg(r, (r == 6) ? 64'h0 :
                                (r == 7) ? 64'h0001_0000_0000_0000 :
                                {rand_coef(), rand_coef()});
          default: write_reg(r, {$urandom, $urandom});
        endcase
      end
      random_vertices(220);
    end
    in_if.valid <= 1'b0;
    no_idle = 1'b0;
    drain();

    $display("covered %0d vertex items, %0d results, over 8 matrix settings", sent,
             result_count);
    $display("settings: identity, all ones, max and min coefficients, random, projective");
    if (fail_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
